@@ rtl/core/sit_pkg.sv @@
// Shared types and constants for the sorted insert table.
package sit_pkg;

  localparam int SIT_DEPTH = 64;
  localparam int DATE_W    = 24;
  localparam int IDENT_W   = 31;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 7;
  localparam int ENTRY_W   = DATE_W + IDENT_W;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic [DATE_W-1:0]  date;
    logic [IDENT_W-1:0] ident;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CHK = 6'b000100,
    S_LK_RD   = 6'b001000,
    S_LK_CHK  = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

endpackage

@@ rtl/core/sit_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/sorted_insert_table_with_key_lookup.sv @@
// Top level: date-sorted entry table with insert and identifier lookup.
// Insert runs a downward shift scan, one entry a cycle through the single RAM
// read port; an insert into a full table is dropped without a scan.
// Lookup runs an upward scan, one entry a cycle.
// One word at a time; a finished result waits in the output register.
// Synchronous reset empties the table (fill count to zero); RAM is not cleared.
module sorted_insert_table_with_key_lookup #(
  parameter int DEPTH = sit_pkg::SIT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [sit_pkg::DATE_W-1:0]  date_key,
  input  logic [sit_pkg::IDENT_W-1:0] ident,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [sit_pkg::POS_W-1:0]   position,
  output logic                        dropped,
  output logic [sit_pkg::COUNT_W-1:0] count
);
  import sit_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  state_t state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] idx_m1, idx_m2, idx_p1;
  logic [DATE_W-1:0]  key_date, key_date_next;
  logic [IDENT_W-1:0] key_ident, key_ident_next;
  logic          res_found, res_found_next;
  logic          res_drop, res_drop_next;
  logic [CW-1:0] res_pos, res_pos_next;
  logic          out_valid_next;
  logic          load_out;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  entry_t        new_entry;

  logic [CW+POS_W-1:0]   pos_ext;
  logic [CW+COUNT_W-1:0] cnt_ext;

  sit_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign idx_m1    = idx - CW'(1);
  assign idx_m2    = idx - CW'(2);
  assign idx_p1    = idx + CW'(1);
  assign new_entry = '{date: key_date, ident: key_ident};
  assign load_out  = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    fill_next      = fill;
    key_date_next  = key_date;
    key_ident_next = key_ident;
    res_found_next = res_found;
    res_drop_next  = res_drop;
    res_pos_next   = res_pos;
    we             = 1'b0;
    waddr          = idx[AW-1:0];
    wdata          = new_entry;
    raddr          = idx_m1[AW-1:0];
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_date_next  = date_key;
          key_ident_next = ident;
          res_found_next = 1'b0;
          res_drop_next  = 1'b0;
          res_pos_next   = '0;
          if (kind == KIND_LOOKUP) begin
            idx_next   = '0;
            state_next = S_LK_RD;
          end else if (fill == FULL) begin
            res_drop_next = 1'b1;
            state_next    = S_DONE;
          end else begin
            idx_next   = fill;
            state_next = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        if (idx == '0) begin
          we           = 1'b1;
          fill_next    = fill + CW'(1);
          res_pos_next = '0;
          state_next   = S_DONE;
        end else begin
          raddr      = idx_m1[AW-1:0];
          state_next = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        we = 1'b1;
        if (rdata.date >= key_date) begin
          wdata    = rdata;
          idx_next = idx_m1;
          if (idx_m1 == '0) begin
            state_next = S_INS_RD;
          end else begin
            raddr = idx_m2[AW-1:0];
          end
        end else begin
          fill_next    = fill + CW'(1);
          res_pos_next = idx;
          state_next   = S_DONE;
        end
      end
      S_LK_RD: begin
        if (idx == fill) begin
          state_next = S_DONE;
        end else begin
          raddr      = idx[AW-1:0];
          state_next = S_LK_CHK;
        end
      end
      S_LK_CHK: begin
        if (rdata.ident == key_ident) begin
          res_found_next = 1'b1;
          res_pos_next   = idx;
          state_next     = S_DONE;
        end else if (idx_p1 == fill) begin
          state_next = S_DONE;
        end else begin
          raddr    = idx_p1[AW-1:0];
          idx_next = idx_p1;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign pos_ext = {{POS_W{1'b0}}, res_pos};
  assign cnt_ext = {{COUNT_W{1'b0}}, fill};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
    end
    idx       <= idx_next;
    key_date  <= key_date_next;
    key_ident <= key_ident_next;
    res_found <= res_found_next;
    res_drop  <= res_drop_next;
    res_pos   <= res_pos_next;
    if (load_out) begin
      found    <= res_found;
      dropped  <= res_drop;
      position <= pos_ext[POS_W-1:0];
      count    <= cnt_ext[COUNT_W-1:0];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count above table depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE || state == S_LK_RD || state == S_LK_CHK) |-> !we)
    else $error("table written outside an insert");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dropped) |-> (!found && position == '0))
    else $error("dropped word carries a hit or a position");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (fill != $past(fill)) |-> (fill == $past(fill) + CW'(1)))
    else $error("fill count moved by other than one");

endmodule

@@ tb/sit_result_checker.sv @@
// Checker for the sorted insert table: predicts each result word and compares it.
module sit_result_checker
  import sit_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               kind,
  input  logic [DATE_W-1:0]  date_key,
  input  logic [IDENT_W-1:0] ident,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               found,
  input  logic [POS_W-1:0]   position,
  input  logic               dropped,
  input  logic [COUNT_W-1:0] count,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct {
    logic               found;
    logic [POS_W-1:0]   position;
    logic               dropped;
    logic [COUNT_W-1:0] count;
  } answer_t;

  answer_t answer_q[$];
  entry_t  slots[SIT_DEPTH];
  int      fill;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    fill        = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Updates the shadow table and returns the answer for one input word.
  function automatic answer_t apply_word(logic k, logic [DATE_W-1:0] d,
                                         logic [IDENT_W-1:0] id);
    answer_t a;
    int      p;
    int      i;
    a.found    = 1'b0;
    a.position = '0;
    a.dropped  = 1'b0;
    if (k == KIND_INSERT) begin
      if (fill >= SIT_DEPTH) begin
        a.dropped = 1'b1;
      end else begin
        p = 0;
        while (p < fill && slots[p].date < d) p++;
        for (i = fill; i > p; i--) slots[i] = slots[i-1];
        slots[p].date  = d;
        slots[p].ident = id;
        fill++;
        a.position = POS_W'(p);
      end
    end else begin
      for (i = 0; i < fill && !a.found; i++) begin
        if (slots[i].ident == id) begin
          a.found    = 1'b1;
          a.position = POS_W'(i);
        end
      end
    end
    a.count = COUNT_W'(fill);
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(count), 0);
        end else begin
          want = answer_q.pop_front();
          if (found !== want.found) report_mismatch("found", 32'(found), 32'(want.found));
          if (position !== want.position)
            report_mismatch("position", 32'(position), 32'(want.position));
          if (dropped !== want.dropped)
            report_mismatch("dropped", 32'(dropped), 32'(want.dropped));
          if (count !== want.count) report_mismatch("count", 32'(count), 32'(want.count));
        end
      end
      if (in_valid && !in_stall) answer_q.push_back(apply_word(kind, date_key, ident));
    end
    outstanding <= answer_q.size();
  end

endmodule

@@ tb/sorted_insert_table_with_key_lookup_tb.sv @@
// Testbench top for the sorted insert table: stimulus, stall patterns and verdict.
module sorted_insert_table_with_key_lookup_tb;
  import sit_pkg::*;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               kind      = KIND_INSERT;
  logic [DATE_W-1:0]  date_key  = '0;
  logic [IDENT_W-1:0] ident     = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               found;
  logic [POS_W-1:0]   position;
  logic               dropped;
  logic [COUNT_W-1:0] count;

  int fail_count;
  int outstanding;
  int burst_left = 0;
  int stored     = 0;
  int stall_left = 0;
  int stall_pct  = 0;

  logic [IDENT_W-1:0] used_idents[$];
  logic [DATE_W-1:0]  used_dates[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sorted_insert_table_with_key_lookup u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .date_key (date_key),
    .ident    (ident),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found    (found),
    .position (position),
    .dropped  (dropped),
    .count    (count)
  );

  sit_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .date_key   (date_key),
    .ident      (ident),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .position   (position),
    .dropped    (dropped),
    .count      (count),
    .mismatches (fail_count),
    .outstanding(outstanding)
  );

  // Receiver stalls in stretches of varying density, including none.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 60;
        default: stall_pct = 95;
      endcase
      stall_left = $urandom_range(50, 400);
    end
    stall_left--;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_word(logic k, logic [DATE_W-1:0] d, logic [IDENT_W-1:0] id);
    kind     <= k;
    date_key <= d;
    ident    <= id;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (k == KIND_INSERT && stored < SIT_DEPTH) begin
      stored++;
      used_idents.push_back(id);
      used_dates.push_back(d);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic               is_insert;
    logic [DATE_W-1:0]  d;
    logic [IDENT_W-1:0] id;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, equal dates, duplicate idents
    send_word(KIND_LOOKUP, '0, '0);
    send_word(KIND_INSERT, 24'h123456, 31'd5);
    send_word(KIND_INSERT, '1, '1);
    send_word(KIND_INSERT, '0, '0);
    send_word(KIND_INSERT, 24'h123456, 31'd7);
    send_word(KIND_INSERT, 24'h123456, 31'd5);
    send_word(KIND_LOOKUP, '1, 31'd5);
    send_word(KIND_LOOKUP, 24'h5a5a5a, '1);
    send_word(KIND_LOOKUP, '0, '0);
    send_word(KIND_LOOKUP, '0, 31'h2aaaaaaa);
    send_word(KIND_INSERT, 24'haaaaaa, 31'h55555555);
    send_word(KIND_INSERT, 24'h555555, 31'h2aaaaaaa);
    send_word(KIND_LOOKUP, 24'h000001, 31'h2aaaaaaa);
    send_word(KIND_LOOKUP, '0, 31'd7);
    wait_for_results();

    // random: table fills slowly, then dropped inserts mix with lookups
    for (int n = 0; n < 1550; n++) begin
      if ($urandom_range(0, 99) < 2) wait_for_results();
      is_insert = (stored < SIT_DEPTH) ? ($urandom_range(0, 99) < 7)
                                       : ($urandom_range(0, 99) < 20);
      if (is_insert) begin
        case ($urandom_range(0, 9))
          0: d = '0;
          1: d = '1;
          2, 3, 4: d = (used_dates.size() != 0)
                       ? used_dates[$urandom_range(0, used_dates.size() - 1)]
                       : DATE_W'($urandom);
          default: d = DATE_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0: id = '0;
          1: id = '1;
          2: id = (used_idents.size() != 0)
                  ? used_idents[$urandom_range(0, used_idents.size() - 1)]
                  : IDENT_W'($urandom);
          default: id = IDENT_W'($urandom);
        endcase
        send_word(KIND_INSERT, d, id);
      end else begin
        case ($urandom_range(0, 19))
          0: id = '0;
          1: id = '1;
          2, 3, 4: id = IDENT_W'($urandom);
          default: id = (used_idents.size() != 0)
                        ? used_idents[$urandom_range(0, used_idents.size() - 1)]
                        : IDENT_W'($urandom);
        endcase
        send_word(KIND_LOOKUP, DATE_W'($urandom), id);
      end
    end

    wait_for_results();
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
